/* rtl/core/rv32_pkg.sv */
// shared types and constants for the rv32im execute unit
package rv32_pkg;

  typedef struct packed {
    logic [5:0]         action;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
  } exec_in_t;

  typedef struct packed {
    logic [31:0] write_value;
    logic        write_enable;
    logic        branch_taken;
    logic [31:0] next_pc;
  } exec_out_t;

  localparam logic [5:0] OP_LUI    = 6'd0;
  localparam logic [5:0] OP_AUIPC  = 6'd1;
  localparam logic [5:0] OP_ADDI   = 6'd2;
  localparam logic [5:0] OP_SLTI   = 6'd3;
  localparam logic [5:0] OP_SLTIU  = 6'd4;
  localparam logic [5:0] OP_XORI   = 6'd5;
  localparam logic [5:0] OP_ORI    = 6'd6;
  localparam logic [5:0] OP_ANDI   = 6'd7;
  localparam logic [5:0] OP_SLLI   = 6'd8;
  localparam logic [5:0] OP_SRLI   = 6'd9;
  localparam logic [5:0] OP_SRAI   = 6'd10;
  localparam logic [5:0] OP_ADD    = 6'd11;
  localparam logic [5:0] OP_SUB    = 6'd12;
  localparam logic [5:0] OP_SLL    = 6'd13;
  localparam logic [5:0] OP_SLT    = 6'd14;
  localparam logic [5:0] OP_SLTU   = 6'd15;
  localparam logic [5:0] OP_XOR    = 6'd16;
  localparam logic [5:0] OP_SRL    = 6'd17;
  localparam logic [5:0] OP_SRA    = 6'd18;
  localparam logic [5:0] OP_OR     = 6'd19;
  localparam logic [5:0] OP_AND    = 6'd20;
  localparam logic [5:0] OP_JAL    = 6'd21;
  localparam logic [5:0] OP_JALR   = 6'd22;
  localparam logic [5:0] OP_BEQ    = 6'd23;
  localparam logic [5:0] OP_BNE    = 6'd24;
  localparam logic [5:0] OP_BLT    = 6'd25;
  localparam logic [5:0] OP_BGE    = 6'd26;
  localparam logic [5:0] OP_BLTU   = 6'd27;
  localparam logic [5:0] OP_BGEU   = 6'd28;
  localparam logic [5:0] OP_MUL    = 6'd29;
  localparam logic [5:0] OP_MULH   = 6'd30;
  localparam logic [5:0] OP_MULHSU = 6'd31;
  localparam logic [5:0] OP_MULHU  = 6'd32;
  localparam logic [5:0] OP_DIV    = 6'd33;
  localparam logic [5:0] OP_DIVU   = 6'd34;
  localparam logic [5:0] OP_REM    = 6'd35;
  localparam logic [5:0] OP_REMU   = 6'd36;

  // multiply/divide request and result between sequencer and iterative unit
  typedef struct packed {
    logic        start;
    logic        is_div;
    logic        a_signed;
    logic        b_signed;
    logic [31:0] a;
    logic [31:0] b;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] lo;
    logic [31:0] hi;
  } md_rsp_t;

endpackage

/* rtl/core/rv32_muldiv.sv */
// iterative radix-2 multiply and divide unit shared by all m-extension ops
module rv32_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  rv32_pkg::md_req_t req,
  output rv32_pkg::md_rsp_t rsp
);
  import rv32_pkg::*;

  logic        busy;
  logic [5:0]  count;
  logic        is_div;
  logic        neg_res;
  logic        neg_rem;
  logic [31:0] mag_b;
  logic [63:0] acc;
  logic [31:0] quot;
  logic [32:0] rem;
  logic        fin;

  logic [31:0] mag_a_w, mag_b_w;
  logic        a_neg, b_neg;
  logic [32:0] rem_shift;
  logic [32:0] rem_sub;
  logic [63:0] prod_w;
  logic [31:0] q_w, r_w;

  assign a_neg   = req.a_signed & req.a[31];
  assign b_neg   = req.b_signed & req.b[31];
  assign mag_a_w = a_neg ? (32'd0 - req.a) : req.a;
  assign mag_b_w = b_neg ? (32'd0 - req.b) : req.b;

  // one restoring divide step per cycle
  assign rem_shift = {rem[31:0], quot[31]};
  assign rem_sub   = rem_shift - {1'b0, mag_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && count == 6'd31) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      count   <= 6'd0;
      is_div  <= req.is_div;
      mag_b   <= req.is_div ? mag_b_w : mag_b_w;
      neg_res <= a_neg ^ b_neg;
      neg_rem <= a_neg;
      acc     <= {32'd0, mag_a_w};
      quot    <= mag_a_w;
      rem     <= 33'd0;
    end else if (busy) begin
      count <= count + 6'd1;
      if (is_div) begin
        if (!rem_sub[32]) begin
          rem  <= rem_sub;
          quot <= {quot[30:0], 1'b1};
        end else begin
          rem  <= rem_shift;
          quot <= {quot[30:0], 1'b0};
        end
      end else begin
        // shift-add multiply, lsb of acc selects the add
        acc <= {({1'b0, acc[63:32]} + (acc[0] ? {1'b0, mag_b} : 33'd0)), acc[31:1]};
      end
    end
  end

  assign prod_w = neg_res ? (64'd0 - acc) : acc;
  assign q_w    = neg_res ? (32'd0 - quot) : quot;
  assign r_w    = neg_rem ? (32'd0 - rem[31:0]) : rem[31:0];

  assign rsp.done = fin;
  assign rsp.lo   = is_div ? q_w : prod_w[31:0];
  assign rsp.hi   = is_div ? r_w : prod_w[63:32];

  assert property (@(posedge clk) disable iff (rst) fin |-> !busy)
    else $error("done while busy");
  assert property (@(posedge clk) disable iff (rst) busy |-> count <= 6'd31)
    else $error("step count overrun");
  assert property (@(posedge clk) disable iff (rst) fin |=> !fin)
    else $error("done held two cycles");
endmodule

/* rtl/core/rv32im_execute_unit.sv */
// rv32im execute unit top level: register file, pc, alu and sequencer
//  channel | dir | valid | stall | payload
//  in      | in  | valid | stall | exec_in_t
//  out     | out | out_valid | out_stall | exec_out_t
// single-cycle ops go from accept through S_EXEC to the registered result in S_OUT; m ops
// also wait in S_MD for the 32 steps of the shared shift-add / restoring divide unit.
// the input is stalled from accept until the result has been taken.
// rst clears the register file and pc at once; no clearing pass.
// a stalled result holds until taken.
module rv32im_execute_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                stall,
  input  rv32_pkg::exec_in_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output rv32_pkg::exec_out_t out_item
);
  import rv32_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_MD   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  state;
  logic [31:0] regs [32];
  logic [31:0] pc;
  exec_in_t    cur;
  logic [31:0] a, b;
  md_req_t     req;
  md_rsp_t     rsp;

  logic [31:0] imm, pc4, val, nxt, mdv;
  logic        wr, tk, cond, is_md, is_div;
  logic [4:0]  sh;
  logic        lts, ltu;
  logic [31:0] div_fix;
  logic        div_z, div_ovf;

  assign stall = (state != S_IDLE);
  assign imm   = cur.immediate;
  assign pc4   = pc + 32'd4;
  assign is_md  = (cur.action >= OP_MUL) && (cur.action <= OP_REMU);
  assign is_div = (cur.action >= OP_DIV);

  always_comb begin
    lts = ($signed(a) < $signed(b));
    ltu = (a < b);
    case (cur.action)
      OP_SLTI, OP_SLTIU, OP_SLLI, OP_SRLI, OP_SRAI: begin
        lts = ($signed(a) < $signed(imm));
        ltu = (a < imm);
      end
      default: ;
    endcase
    sh = (cur.action <= OP_SRAI) ? imm[4:0] : b[4:0];
  end

  // divide by zero and signed overflow bypass the iterative result
  assign div_z   = (b == 32'd0);
  assign div_ovf = (a == 32'h8000_0000) && (b == 32'hFFFF_FFFF);
  always_comb begin
    div_fix = 32'd0;
    case (cur.action)
      OP_DIV:  div_fix = div_z ? 32'hFFFF_FFFF : 32'h8000_0000;
      OP_DIVU: div_fix = 32'hFFFF_FFFF;
      OP_REM:  div_fix = div_z ? a : 32'd0;
      default: div_fix = a;
    endcase
  end

  always_comb begin
    val  = 32'd0;
    wr   = 1'b1;
    tk   = 1'b0;
    cond = 1'b0;
    nxt  = pc4;
    // low half carries the product low word and the quotient
    mdv  = (cur.action == OP_MUL || cur.action == OP_DIV || cur.action == OP_DIVU) ?
           rsp.lo : rsp.hi;
    case (cur.action)
      OP_LUI:   val = imm << 12;
      OP_AUIPC: val = pc + (imm << 12);
      OP_ADDI:  val = a + imm;
      OP_SLTI, OP_SLT:   val = {31'd0, lts};
      OP_SLTIU, OP_SLTU: val = {31'd0, ltu};
      OP_XORI:  val = a ^ imm;
      OP_ORI:   val = a | imm;
      OP_ANDI:  val = a & imm;
      OP_SLLI, OP_SLL: val = a << sh;
      OP_SRLI, OP_SRL: val = a >> sh;
      OP_SRAI, OP_SRA: val = 32'($signed(a) >>> sh);
      OP_ADD:   val = a + b;
      OP_SUB:   val = a - b;
      OP_XOR:   val = a ^ b;
      OP_OR:    val = a | b;
      OP_AND:   val = a & b;
      OP_JAL: begin
        val = pc4; nxt = pc + imm; tk = 1'b1;
      end
      OP_JALR: begin
        val = pc4; nxt = (a + imm) & ~32'd1; tk = 1'b1;
      end
      OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: begin
        wr = 1'b0;
        case (cur.action)
          OP_BEQ:  cond = (a == b);
          OP_BNE:  cond = (a != b);
          OP_BLT:  cond = lts;
          OP_BGE:  cond = !lts;
          OP_BLTU: cond = ltu;
          default: cond = !ltu;
        endcase
        if (cond) begin
          nxt = pc + imm; tk = 1'b1;
        end
      end
      OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU: val = mdv;
      OP_DIV, OP_REM: val = (div_z || div_ovf) ? div_fix : mdv;
      OP_DIVU, OP_REMU: val = div_z ? div_fix : mdv;
      default: wr = 1'b0;
    endcase
    if (cur.dest_reg == 5'd0) wr = 1'b0;
    if (!wr) val = 32'd0;
  end

  always_comb begin
    req.start     = (state == S_EXEC) && is_md;
    req.is_div    = is_div;
    req.a_signed  = (cur.action == OP_MULH) || (cur.action == OP_MULHSU) ||
                    (cur.action == OP_DIV) || (cur.action == OP_REM);
    req.b_signed  = (cur.action == OP_MULH) ||
                    (cur.action == OP_DIV) || (cur.action == OP_REM);
    req.a         = a;
    req.b         = b;
  end

  rv32_muldiv u_md (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= 32'd0;
      for (int i = 0; i < 32; i++) regs[i] <= 32'd0;
    end else begin
      case (state)
        S_IDLE: if (valid) begin
          cur   <= in_item;
          a     <= regs[in_item.src1_reg];
          b     <= regs[in_item.src2_reg];
          state <= S_EXEC;
        end
        S_EXEC, S_MD: if ((state == S_EXEC && !is_md) || (state == S_MD && rsp.done)) begin
          out_item.write_value  <= val;
          out_item.write_enable <= wr;
          out_item.branch_taken <= tk;
          out_item.next_pc      <= nxt;
          pc <= nxt;
          if (wr) regs[cur.dest_reg] <= val;
          state <= S_OUT;
        end else if (state == S_EXEC) begin
          state <= S_MD;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid = (state == S_OUT);

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.write_enable) |-> out_item.write_value == regs[cur.dest_reg])
    else $error("written value differs from register file");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> pc == out_item.next_pc)
    else $error("pc not updated to next_pc");
  assert property (@(posedge clk) disable iff (rst) rsp.done |-> state == S_MD)
    else $error("unit finished outside multiply/divide wait");
endmodule
